// File: hdl/ibad_pkg.sv
// shared constants and types of the block average downscaler
// no dependencies; used by the top level

package ibad_pkg;

    localparam int MAX_COLS_DEF    = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int MAX_ROWS   = 4096;
    localparam int ROW_W      = 12;
    localparam int ROWS_W     = 13;
    localparam int COLS_CFG_W = 13;
    localparam int BS_W       = 5;
    localparam int MAX_BS     = 16;
    localparam int LOC_W      = 4;
    localparam int K_W        = 9;
    localparam int DIV_STEP   = 4;
    localparam int VAL_W      = 32;
    localparam int COORD_W    = 12;
    localparam int OUT_W      = VAL_W + 2 * COORD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_AREA = 3'd4;

    localparam logic [BS_W-1:0]       BLOCK_SIZE_RST = 5'd2;
    localparam logic [ROWS_W-1:0]     FINE_ROWS_RST  = 13'd4096;
    localparam logic [COLS_CFG_W-1:0] FINE_COLS_RST  = 13'd4096;
    localparam logic [31:0]           PIXEL_AREA_RST = 32'd65536;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_div_state;

endpackage

// File: hdl/image_block_average_downscale_unit.sv
// top level of the block average downscaler: raster counters, tile sum ram,
// scaling multiplier and radix-16 divider; depends on ibad_pkg and ibad_ram
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid / s_axis_tready  one fine pixel per beat
//  m_axis    out  m_axis_tvalid / m_axis_tready  one coarse pixel per beat
//  cfg       in   i_cfg_valid / o_cfg_ready      register index and value
//
// pixels that do not end a tile are taken one per cycle; the tile sum ram is
// read at accept and written in the next cycle, with forwarding of the last write
// a tile-ending pixel holds the input through the multiplier stage and
// the 4-bit-per-cycle divider
// a stalled output holds the divider result and with it the input
// synchronous active-low reset; the ram needs no clearing pass

module image_block_average_downscale_unit #(
    parameter int MAX_COLS    = ibad_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = ibad_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // coarse_value, coarse_row, coarse_col
    output logic [ibad_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ibad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ibad_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW       = $clog2(MAX_COLS);
    localparam int SUM_W    = SAMPLE_BITS + 8;
    localparam int NUM_W    = SUM_W + 16;
    localparam int DIV_ITER = (NUM_W + ibad_pkg::DIV_STEP - 1) / ibad_pkg::DIV_STEP;
    localparam int DIV_W    = DIV_ITER * ibad_pkg::DIV_STEP;
    localparam int ITW      = $clog2(DIV_ITER);
    localparam int RW       = ibad_pkg::ROW_W;
    localparam int LW       = ibad_pkg::LOC_W;
    localparam int KW       = ibad_pkg::K_W;
    localparam logic [15:0] MAX_COLS16 = 16'(MAX_COLS);

    // configuration registers
    logic [ibad_pkg::BS_W-1:0]       r_block_size;
    logic [ibad_pkg::ROWS_W-1:0]     r_fine_rows;
    logic [ibad_pkg::COLS_CFG_W-1:0] r_fine_cols;
    logic                            r_integrate;
    logic [31:0]                     r_pixel_area;

    // raster position
    logic [CW-1:0] r_col, r_tc, r_cbase;
    logic [LW-1:0] r_lc, r_lr;
    logic [RW-1:0] r_row, r_tr, r_rbase;

    // accumulate stage
    logic                   r_p1_valid, r_p1_first, r_p1_emit, r_p1_last;
    logic [CW-1:0]          r_p1_addr;
    logic [RW-1:0]          r_p1_row;
    logic [SAMPLE_BITS-1:0] r_p1_sample;

    logic             r_w_valid;
    logic [CW-1:0]    r_w_addr;
    logic [SUM_W-1:0] r_w_sum;

    // divider
    ibad_pkg::t_div_state r_state;
    logic                 r_neg, r_d_last;
    logic [SUM_W-1:0]     r_mag;
    logic [RW-1:0]        r_d_row;
    logic [CW-1:0]        r_d_col;
    logic [DIV_W-1:0]     r_quo;
    logic [KW-1:0]        r_rem;
    logic [ITW-1:0]       r_iter;

    // output register
    logic                             r_out_valid, r_out_last;
    logic [ibad_pkg::OUT_W-1:0]       r_out_data;

    logic [ibad_pkg::BS_W-1:0] bs_eff, bs_m1;
    logic [ibad_pkg::ROWS_W-1:0] rows_eff;
    logic [15:0]               cols16;
    logic [CW:0]               cols_eff;
    logic [KW-1:0]             k;
    logic                      lc_end, lr_end, col_wrap, row_wrap;
    logic                      tile_ok, tile_last;
    logic                      acc, geo_wr, load_out;
    logic [SUM_W-1:0]          rd_data, base, sum, sample_ext;
    logic [SUM_W+31:0]         prod;
    logic [NUM_W-1:0]          numer;
    logic [DIV_W-1:0]          quo_step;
    logic [KW-1:0]             rem_step;
    logic [DIV_W+32:0]         q_ext, lim_ext;
    logic [31:0]               q_sat, val;
    logic [CW+11:0]            col_ext;

    always_comb begin
        if (r_block_size == '0) begin
            bs_eff = 5'd1;
        end else if (r_block_size > 5'(ibad_pkg::MAX_BS)) begin
            bs_eff = 5'(ibad_pkg::MAX_BS);
        end else begin
            bs_eff = r_block_size;
        end
        if (r_fine_rows == '0) begin
            rows_eff = 13'd1;
        end else if (r_fine_rows > 13'(ibad_pkg::MAX_ROWS)) begin
            rows_eff = 13'(ibad_pkg::MAX_ROWS);
        end else begin
            rows_eff = r_fine_rows;
        end
        cols16 = 16'(r_fine_cols);
        if (r_fine_cols == '0) begin
            cols_eff = (CW+1)'(1);
        end else if (cols16 > MAX_COLS16) begin
            cols_eff = MAX_COLS16[CW:0];
        end else begin
            cols_eff = cols16[CW:0];
        end
    end

    assign bs_m1 = bs_eff - 5'd1;
    assign k     = KW'(bs_eff) * KW'(bs_eff);

    assign lc_end   = (5'(r_lc) == bs_m1);
    assign lr_end   = (5'(r_lr) == bs_m1);
    assign col_wrap = ((CW+1)'(r_col) + (CW+1)'(1)) >= cols_eff;
    assign row_wrap = (13'(r_row) + 13'd1) >= rows_eff;

    assign tile_ok = (((CW+1)'(r_cbase) + (CW+1)'(bs_eff)) <= cols_eff)
                  && ((13'(r_rbase) + 13'(bs_eff)) <= rows_eff);
    assign tile_last = (((CW+2)'(r_cbase) + ((CW+2)'(bs_eff) << 1)) > (CW+2)'(cols_eff))
                    && ((14'(r_rbase) + (14'(bs_eff) << 1)) > 14'(rows_eff));

    assign s_axis_tready = (r_state == ibad_pkg::S_IDLE) && !(r_p1_valid && r_p1_emit);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign geo_wr        = i_cfg_valid && ((i_cfg_index == ibad_pkg::CFG_BLOCK_SIZE)
                        || (i_cfg_index == ibad_pkg::CFG_FINE_ROWS)
                        || (i_cfg_index == ibad_pkg::CFG_FINE_COLS));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= ibad_pkg::BLOCK_SIZE_RST;
            r_fine_rows  <= ibad_pkg::FINE_ROWS_RST;
            r_fine_cols  <= ibad_pkg::FINE_COLS_RST;
            r_integrate  <= 1'b0;
            r_pixel_area <= ibad_pkg::PIXEL_AREA_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ibad_pkg::CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[ibad_pkg::BS_W-1:0];
                ibad_pkg::CFG_FINE_ROWS:  r_fine_rows  <= i_cfg_data[ibad_pkg::ROWS_W-1:0];
                ibad_pkg::CFG_FINE_COLS:  r_fine_cols  <= i_cfg_data[ibad_pkg::COLS_CFG_W-1:0];
                ibad_pkg::CFG_INTEGRATE:  r_integrate  <= i_cfg_data[0];
                ibad_pkg::CFG_PIXEL_AREA: r_pixel_area <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geo_wr) begin
            r_col   <= '0;
            r_lc    <= '0;
            r_tc    <= '0;
            r_cbase <= '0;
            r_row   <= '0;
            r_lr    <= '0;
            r_tr    <= '0;
            r_rbase <= '0;
        end else if (acc) begin
            if (col_wrap) begin
                r_col   <= '0;
                r_lc    <= '0;
                r_tc    <= '0;
                r_cbase <= '0;
                if (row_wrap) begin
                    r_row   <= '0;
                    r_lr    <= '0;
                    r_tr    <= '0;
                    r_rbase <= '0;
                end else begin
                    r_row <= r_row + RW'(1);
                    if (lr_end) begin
                        r_lr    <= '0;
                        r_tr    <= r_tr + RW'(1);
                        r_rbase <= r_rbase + RW'(bs_eff);
                    end else begin
                        r_lr <= r_lr + LW'(1);
                    end
                end
            end else begin
                r_col <= r_col + CW'(1);
                if (lc_end) begin
                    r_lc    <= '0;
                    r_tc    <= r_tc + CW'(1);
                    r_cbase <= r_cbase + CW'(bs_eff);
                end else begin
                    r_lc <= r_lc + LW'(1);
                end
            end
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_w_valid  <= 1'b0;
        end else begin
            r_p1_valid <= acc && tile_ok;
            r_w_valid  <= r_p1_valid;
        end
        if (acc) begin
            r_p1_first  <= (r_lc == '0) && (r_lr == '0);
            r_p1_emit   <= lc_end && lr_end;
            r_p1_last   <= tile_last;
            r_p1_addr   <= r_tc;
            r_p1_row    <= r_tr;
            r_p1_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        r_w_addr <= r_p1_addr;
        r_w_sum  <= sum;
    end

    ibad_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (r_p1_valid),
        .i_waddr (r_p1_addr),
        .i_wdata (sum),
        .i_raddr (r_tc),
        .o_rdata (rd_data)
    );

    assign sample_ext = SUM_W'($signed(r_p1_sample));

    always_comb begin
        if (r_p1_first) begin
            base = '0;
        end else if (r_w_valid && (r_w_addr == r_p1_addr)) begin
            base = r_w_sum;
        end else begin
            base = rd_data;
        end
        sum = base + sample_ext;
    end

    // scaling and division
    assign prod  = (SUM_W+32)'(r_mag) * (SUM_W+32)'(r_pixel_area);
    assign numer = r_integrate ? prod[SUM_W+31:16] : NUM_W'(r_mag);

    always_comb begin
        logic [KW:0] t;
        logic        b;
        rem_step = r_rem;
        quo_step = r_quo;
        for (int i = 0; i < ibad_pkg::DIV_STEP; i++) begin
            t = {rem_step, quo_step[DIV_W-1]};
            b = (t >= {1'b0, k});
            if (b) begin
                t = t - {1'b0, k};
            end
            rem_step = t[KW-1:0];
            quo_step = {quo_step[DIV_W-2:0], b};
        end
    end

    assign q_ext   = {{33{1'b0}}, r_quo};
    assign lim_ext = {{DIV_W{1'b0}}, (r_neg ? 33'h080000000 : 33'h07fffffff)};
    assign q_sat   = (q_ext > lim_ext) ? lim_ext[31:0] : q_ext[31:0];
    assign val     = r_neg ? (~q_sat + 32'd1) : q_sat;
    assign col_ext = {12'b0, r_d_col};

    assign load_out = (r_state == ibad_pkg::S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibad_pkg::S_IDLE;
        end else begin
            unique case (r_state)
                ibad_pkg::S_IDLE: begin
                    if (r_p1_valid && r_p1_emit) begin
                        r_state <= ibad_pkg::S_MUL;
                    end
                end
                ibad_pkg::S_MUL: begin
                    r_state <= ibad_pkg::S_DIV;
                end
                ibad_pkg::S_DIV: begin
                    if (r_iter == ITW'(DIV_ITER - 1)) begin
                        r_state <= ibad_pkg::S_DONE;
                    end
                end
                ibad_pkg::S_DONE: begin
                    if (load_out) begin
                        r_state <= ibad_pkg::S_IDLE;
                    end
                end
                default: r_state <= ibad_pkg::S_IDLE;
            endcase
        end
        if (r_state == ibad_pkg::S_IDLE && r_p1_valid && r_p1_emit) begin
            r_neg    <= sum[SUM_W-1];
            r_mag    <= sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
            r_d_row  <= r_p1_row;
            r_d_col  <= r_p1_addr;
            r_d_last <= r_p1_last;
        end
        if (r_state == ibad_pkg::S_MUL) begin
            r_quo  <= DIV_W'(numer);
            r_rem  <= '0;
            r_iter <= '0;
        end else if (r_state == ibad_pkg::S_DIV) begin
            r_quo  <= quo_step;
            r_rem  <= rem_step;
            r_iter <= r_iter + ITW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_out_data <= {col_ext[11:0], r_d_row, val};
            r_out_last <= r_d_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: hdl/ibad_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// read-first on a same-address collision; uses no package items

module ibad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
